@@ src/longest_tandem_repeat_counter_defines.svh @@
// ----------------------------------------------------------------------------
// Longest tandem repeat counter: assertion macros
// Shared concurrent assertion forms, clocked on clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef LONGEST_TANDEM_REPEAT_COUNTER_DEFINES_SVH
`define LONGEST_TANDEM_REPEAT_COUNTER_DEFINES_SVH

// same-cycle implication
`define LTRC_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LTRC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/ltrc_pkg.sv @@
// ----------------------------------------------------------------------------
// Longest tandem repeat counter: package
// Sizes, register indices, shared structs and the pattern length clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ltrc_pkg;

	localparam int MAX_PATTERN_LEN = 8;
	localparam int RUN_COUNT_WIDTH = 16;
	localparam int SYM_W           = 8;
	localparam int LEN_W           = 4;
	localparam int PAT_W           = SYM_W * MAX_PATTERN_LEN;
	localparam int GAP_LIMIT       = 2 * MAX_PATTERN_LEN;
	localparam int GAP_W           = $clog2(GAP_LIMIT + 2);
	localparam int IDX_W           = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
	localparam int CFG_IDX_W       = 1;

	typedef logic [RUN_COUNT_WIDTH-1:0] run_t;
	typedef logic [SYM_W-1:0]           sym_t;
	typedef logic [LEN_W-1:0]           len_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_SYMBOLS = 1'b0,
		REG_PATTERN_LENGTH  = 1'b1
	} cfg_reg_t;

	// per-transfer control broadcast along the cell row
	typedef struct packed {
		logic advance;
		logic last;
	} seq_ctrl_t;

	// what one cell compares against
	typedef struct packed {
		sym_t want;
		logic active;
	} cell_sel_t;

	function automatic len_t used_length(input len_t raw);
		len_t len;
		len = raw;
		if (raw == '0) begin
			len = len_t'(1);
		end else if (raw > len_t'(MAX_PATTERN_LEN)) begin
			len = len_t'(MAX_PATTERN_LEN);
		end
		return len;
	endfunction

endpackage

@@ src/ltrc_cell.sv @@
// ----------------------------------------------------------------------------
// Longest tandem repeat counter: window cell
// Holds one symbol of the recent window, passes it on each transfer and
// flags whether its incoming symbol matches its pattern byte or it is unused.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ltrc_cell import ltrc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  seq_ctrl_t ctrl,
	input  sym_t      sym_in,
	input  cell_sel_t sel,
	output sym_t      sym_q,
	output logic      hit
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q <= '0;
		end else if (ctrl.advance) begin
			sym_q <= ctrl.last ? '0 : sym_in;
		end
	end

	assign hit = !sel.active || (sym_in == sel.want);

endmodule

@@ src/ltrc_run.sv @@
// ----------------------------------------------------------------------------
// Longest tandem repeat counter: run tracker
// Gap since the last copy, current run and best run; gives the longest run
// including the transfer under way.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ltrc_run import ltrc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  seq_ctrl_t ctrl,
	input  logic      match_all,
	input  len_t      len,
	output run_t      longest
);

	logic [GAP_W-1:0] gap_q;
	logic [GAP_W-1:0] gap_n;
	logic [GAP_W-1:0] avail;
	run_t             cur_q;
	run_t             best_q;
	run_t             cur_n;
	run_t             best_n;
	logic             take;

	assign avail = gap_q + GAP_W'(1);
	assign take  = (avail >= GAP_W'(len)) && match_all;

	always_comb begin
		cur_n  = cur_q;
		best_n = best_q;
		gap_n  = avail;
		if (take) begin
			gap_n = '0;
			if (cur_q == '0) begin
				cur_n = run_t'(1);
			end else if (avail == GAP_W'(len)) begin
				if (cur_q != '1) begin
					cur_n = cur_q + run_t'(1);
				end
			end else begin
				if (cur_q > best_q) begin
					best_n = cur_q;
				end
				cur_n = run_t'(1);
			end
		end else if (avail > GAP_W'(GAP_LIMIT)) begin
			gap_n = GAP_W'(GAP_LIMIT);
		end
	end

	assign longest = (cur_n > best_n) ? cur_n : best_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q  <= '0;
			cur_q  <= '0;
			best_q <= '0;
		end else if (ctrl.advance) begin
			if (ctrl.last) begin
				gap_q  <= '0;
				cur_q  <= '0;
				best_q <= '0;
			end else begin
				gap_q  <= gap_n;
				cur_q  <= cur_n;
				best_q <= best_n;
			end
		end
	end

endmodule

@@ src/longest_tandem_repeat_counter.sv @@
// ----------------------------------------------------------------------------
// Longest tandem repeat counter: top level
// Input stream: one symbol per transfer on s_axis, tlast marks the final
// symbol of a sequence. The block finds the longest run of back-to-back,
// non-overlapping copies of the configured pattern (1 to 8 symbols, greedy,
// leftmost first) and gives one result transfer on m_axis per sequence.
// Pattern and its length are written through the cfg channel (index 0:
// pattern bytes, first symbol lowest; index 1: length) while idle.
// Throughput: one symbol per cycle while no held result stalls the input,
// set by the row of window cells and the run tracker. The result is valid
// in the cycle after the tlast transfer.
// A held result that is not taken stalls all input: s_axis_tready stays low
// while m_axis_tvalid is high and m_axis_tready is low.
// Counts saturate at 65535. After the tlast transfer the window and run
// state clear; the configuration is kept.
// Reset: pattern all zero, length 1, window and runs clear, no result held.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "longest_tandem_repeat_counter_defines.svh"

module longest_tandem_repeat_counter import ltrc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [SYM_W-1:0]           s_axis_tdata,   // [7:0] symbol
	input  logic                       s_axis_tlast,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [RUN_COUNT_WIDTH-1:0] m_axis_tdata,   // [15:0] longest_run
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [PAT_W-1:0]           cfg_data
);

	logic [MAX_PATTERN_LEN-1:0][SYM_W-1:0] pattern_q;
	len_t                                  len_raw_q;
	len_t                                  len;
	seq_ctrl_t                             ctrl;
	sym_t                                  cell_in  [MAX_PATTERN_LEN];
	sym_t                                  cell_q   [MAX_PATTERN_LEN];
	cell_sel_t                             cell_sel [MAX_PATTERN_LEN];
	logic [MAX_PATTERN_LEN-1:0]            cell_hit;
	run_t                                  longest;
	logic                                  out_valid_q;
	run_t                                  out_data_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			len_raw_q <= len_t'(1);
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_PATTERN_SYMBOLS: pattern_q <= cfg_data;
				REG_PATTERN_LENGTH:  len_raw_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign len = used_length(len_raw_q);

	// input handshake
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign ctrl.advance  = s_axis_tvalid && s_axis_tready;
	assign ctrl.last     = s_axis_tlast;

	// cell k holds window[k]; compares against pattern byte len-1-k
	always_comb begin
		len_t pos;
		pos = '0;
		for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
			pos                = len - len_t'(k) - len_t'(1);
			cell_sel[k].active = (len_t'(k) < len);
			cell_sel[k].want   = pattern_q[pos[IDX_W-1:0]];
			cell_in[k]         = (k == 0) ? s_axis_tdata : cell_q[(k == 0) ? 0 : k - 1];
		end
	end

	for (genvar g = 0; g < MAX_PATTERN_LEN; g++) begin : g_cell
		ltrc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.sym_in (cell_in[g]),
			.sel    (cell_sel[g]),
			.sym_q  (cell_q[g]),
			.hit    (cell_hit[g])
		);
	end

	ltrc_run u_run (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.match_all (&cell_hit),
		.len       (len),
		.longest   (longest)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.advance && ctrl.last) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.advance && ctrl.last) begin
			out_data_q <= longest;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// checks
	`LTRC_ASSERT_IMPL(a_stall_only_on_held_result, !s_axis_tready,
		m_axis_tvalid && !m_axis_tready, "input stalled without a held result")
	`LTRC_ASSERT_NEXT(a_last_gives_result, s_axis_tvalid && s_axis_tready && s_axis_tlast,
		m_axis_tvalid, "no result after last transfer")
	`LTRC_ASSERT_NEXT(a_no_spurious_result,
		m_axis_tvalid && m_axis_tready && !(s_axis_tvalid && s_axis_tready && s_axis_tlast),
		!m_axis_tvalid, "result appeared without a last transfer")

endmodule
